// ===== src/bds_pkg.sv =====
package bds_pkg;

    // Field widths
    localparam int QTY_W   = 16;
    localparam int WGT_W   = 16;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 16;
    localparam int SCORE_W = 40;
    localparam int SUM_W   = 38;

    // Root of the sum in Q.8: radicand is sum << 8, root has half the bits
    localparam int RAD_W   = SUM_W + 8;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int RREM_W  = ROOT_W + 3;

    // Iteration counts of the shared sequential units
    localparam int ROOT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = SCORE_W;
    localparam int STEP_W     = 6;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Controller state, one-hot
    typedef enum logic [3:0] {
        S_ACC  = 4'b0001,
        S_ROOT = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;     // input transaction taken
        logic root_step;  // one root iteration
        logic root_done;  // last root iteration, root becomes divisor
        logic div_step;   // one quotient bit
        logic load_out;   // result register loaded
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic mode;       // 1 = density
    } t_status;

endpackage

// ===== src/bds_datapath.sv =====
module bds_datapath #(
    parameter int MAX_RESOURCES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_data,
    input  logic [bds_pkg::QTY_W-1:0]     i_quantity,
    input  logic [bds_pkg::WGT_W-1:0]     i_weight,
    input  logic [bds_pkg::VAL_W-1:0]     i_bid_value,
    input  logic                          i_bid_close,
    input  bds_pkg::t_cmd                 i_cmd,
    output bds_pkg::t_status              o_status,
    output logic [bds_pkg::IDX_W-1:0]     o_bid_index,
    output logic [bds_pkg::SCORE_W-1:0]   o_score,
    output logic                          o_zero_divisor
);
    import bds_pkg::*;

    localparam int CNT_W = $clog2(MAX_RESOURCES + 1);

    logic               r_score_mode;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_bid_cnt;
    logic [RAD_W-1:0]   r_rad;
    logic [RREM_W-1:0]  r_rrem, n_rrem;
    logic [ROOT_W-1:0]  r_root, n_root;
    logic [SUM_W-1:0]   r_div;
    logic [SCORE_W-1:0] r_num;
    logic [SUM_W-1:0]   r_drem;
    logic [IDX_W-1:0]   r_out_idx;
    logic [SCORE_W-1:0] r_out_score;
    logic               r_out_zero;

    logic [31:0]        prod;
    logic [SUM_W-1:0]   add;
    logic [SUM_W:0]     sum_ext;
    logic               room;
    logic [RREM_W-1:0]  rrem_sh, rtrial;
    logic [SUM_W:0]     drem_sh;
    logic               dge;

    // Element accumulation with saturation; full rows add nothing
    always_comb begin
        prod    = i_quantity * i_weight;
        add     = r_score_mode ? {{(SUM_W-32){1'b0}}, prod}
                               : {{(SUM_W-QTY_W-8){1'b0}}, i_quantity, 8'h00};
        sum_ext = {1'b0, r_sum} + {1'b0, add};
        room    = (r_cnt < CNT_W'(MAX_RESOURCES));
        if (!room) begin
            n_sum = r_sum;
        end else if (sum_ext[SUM_W]) begin
            n_sum = SUM_MAX;
        end else begin
            n_sum = sum_ext[SUM_W-1:0];
        end
    end

    // One root iteration: two radicand bits in, one root bit out
    always_comb begin
        rrem_sh = {r_rrem[RREM_W-3:0], r_rad[RAD_W-1 -: 2]};
        rtrial  = {1'b0, r_root, 2'b01};
        if (rrem_sh >= rtrial) begin
            n_rrem = rrem_sh - rtrial;
            n_root = {r_root[ROOT_W-2:0], 1'b1};
        end else begin
            n_rrem = rrem_sh;
            n_root = {r_root[ROOT_W-2:0], 1'b0};
        end
    end

    // One restoring-division step; a zero divisor yields all ones
    always_comb begin
        drem_sh = {r_drem, r_num[SCORE_W-1]};
        dge     = (drem_sh >= {1'b0, r_div});
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_mode <= 1'b1;
            r_sum        <= '0;
            r_cnt        <= '0;
            r_bid_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_score_mode <= i_cfg_data;
            end
            // last element: bid closes, accumulator starts over
            if (i_cmd.accept) begin
                if (i_bid_close) begin
                    r_sum <= '0;
                    r_cnt <= '0;
                end else begin
                    r_sum <= n_sum;
                    if (room) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
            end
            if (i_cmd.load_out) begin
                r_bid_cnt <= r_bid_cnt + 1'b1;
            end
        end
    end

    // Payload: root, divide and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rad  <= {n_sum, 8'h00};
            r_rrem <= '0;
            r_root <= '0;
            r_div  <= n_sum;
            r_num  <= {i_bid_value, 8'h00};
            r_drem <= '0;
        end
        if (i_cmd.root_step) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rrem <= n_rrem;
            r_root <= n_root;
        end
        if (i_cmd.root_done) begin
            r_div <= {{(SUM_W-ROOT_W){1'b0}}, n_root};
        end
        if (i_cmd.div_step) begin
            r_drem <= dge ? SUM_W'(drem_sh - {1'b0, r_div}) : drem_sh[SUM_W-1:0];
            r_num  <= {r_num[SCORE_W-2:0], dge};
        end
        if (i_cmd.load_out) begin
            r_out_idx   <= r_bid_cnt;
            r_out_score <= r_num;
            r_out_zero  <= (r_div == '0);
        end
    end

    assign o_status.mode  = r_score_mode;
    assign o_bid_index    = r_out_idx;
    assign o_score        = r_out_score;
    assign o_zero_divisor = r_out_zero;

endmodule

// ===== src/bds_ctrl.sv =====
module bds_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_last_of_bid,
    input  logic              i_out_ready,
    input  bds_pkg::t_status  i_status,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output bds_pkg::t_cmd     o_cmd,
    output logic              o_bid_close
);
    import bds_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_bid_close = 1'b0;
        unique case (r_state)
            S_ACC: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_last_of_bid) begin
                        o_bid_close = 1'b1;
                        n_step      = '0;
                        n_state     = i_status.mode ? S_ROOT : S_DIV;
                    end
                end
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_step          = r_step + 1'b1;
                if (r_step == STEP_W'(ROOT_STEPS - 1)) begin
                    o_cmd.root_done = 1'b1;
                    n_step          = '0;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    // Result register occupancy
    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten");

    // Closing a bid leaves the accumulate state
    a_close_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_bid_close |=> (r_state != S_ACC))
        else $error("bid close did not start scoring");

    // A new result only appears after the finish state
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result without finish");

    // Root completion hands over to the divider
    a_root_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.root_done |=> (r_state == S_DIV && r_step == '0))
        else $error("root did not hand over to divider");

endmodule

// ===== src/bid_density_scorer_core.sv =====
// Channel | valid      | ready       | payload
// in      | i_in_valid | o_in_ready  | i_quantity, i_weight, i_bid_value, i_last_of_bid
// out     | o_out_valid| i_out_ready | o_bid_index, o_score, o_zero_divisor
// cfg     | i_cfg_we   | -           | i_cfg_data (score_mode)
//
// An element that does not close a bid is taken at once; the next can follow straight after.
// A closing element starts the bit-serial divider (average mode) or the bit-serial root
// and then the bit-serial divider (density mode), and then the result is loaded; no further
// element is taken until that load.
// The load waits while the previous result is still held on the output.
// Synchronous active-low reset; score_mode resets to density.
module bid_density_scorer_core #(
    parameter int MAX_RESOURCES = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bds_pkg::QTY_W-1:0]     i_quantity,
    input  logic [bds_pkg::WGT_W-1:0]     i_weight,
    input  logic [bds_pkg::VAL_W-1:0]     i_bid_value,
    input  logic                          i_last_of_bid,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [bds_pkg::IDX_W-1:0]     o_bid_index,
    output logic [bds_pkg::SCORE_W-1:0]   o_score,
    output logic                          o_zero_divisor
);
    import bds_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    bid_close;

    // Sequencer
    bds_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_last_of_bid (i_last_of_bid),
        .i_out_ready   (i_out_ready),
        .i_status      (status),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .o_cmd         (cmd),
        .o_bid_close   (bid_close)
    );

    // Accumulator, root, divider and result registers
    bds_datapath #(
        .MAX_RESOURCES (MAX_RESOURCES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_quantity     (i_quantity),
        .i_weight       (i_weight),
        .i_bid_value    (i_bid_value),
        .i_bid_close    (bid_close),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_bid_index    (o_bid_index),
        .o_score        (o_score),
        .o_zero_divisor (o_zero_divisor)
    );

endmodule

// ===== sim/bid_density_scorer_core_tb.sv =====
`timescale 1ns / 100ps

module bid_density_scorer_core_tb;
    import bds_pkg::*;

    localparam int MAX_RES     = 64;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 70;   // longer than one closing element in density mode
    localparam logic [SCORE_W-1:0] SCORE_SAT = {SCORE_W{1'b1}};

    typedef struct {
        logic [QTY_W-1:0] qty;
        logic [WGT_W-1:0] wgt;
        logic [VAL_W-1:0] val;
        logic             last;
    } t_elem;

    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic [SCORE_W-1:0] score;
        logic               zero;
    } t_score;

    // DUT ports
    logic               i_clk          = 1'b0;
    logic               i_rst_n        = 1'b0;
    logic               i_cfg_we       = 1'b0;
    logic               i_cfg_data     = 1'b0;
    logic               i_in_valid     = 1'b0;
    logic               o_in_ready;
    logic [QTY_W-1:0]   i_quantity     = '0;
    logic [WGT_W-1:0]   i_weight       = '0;
    logic [VAL_W-1:0]   i_bid_value    = '0;
    logic               i_last_of_bid  = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready    = 1'b0;
    logic [IDX_W-1:0]   o_bid_index;
    logic [SCORE_W-1:0] o_score;
    logic               o_zero_divisor;

    // Stimulus and expectations
    t_elem  bid_elems[$];
    t_score pending_scores[$];

    // Shadow of the block state
    logic               mdl_mode = 1'b1;
    logic [SUM_W-1:0]   mdl_sum  = '0;
    int                 mdl_cnt  = 0;
    logic [IDX_W-1:0]   mdl_bid  = '0;

    int errors     = 0;
    int n_elems    = 0;
    int n_scores   = 0;
    int n_zero     = 0;
    int n_long     = 0;
    int cycles     = 0;

    bid_density_scorer_core #(
        .MAX_RESOURCES (MAX_RES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_quantity     (i_quantity),
        .i_weight       (i_weight),
        .i_bid_value    (i_bid_value),
        .i_last_of_bid  (i_last_of_bid),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_bid_index    (o_bid_index),
        .o_score        (o_score),
        .o_zero_divisor (o_zero_divisor)
    );

    always #5 i_clk = ~i_clk;

    // Integer square root, greedy from the top bit
    function automatic logic [63:0] floor_root(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= x)
                r = t;
        end
        return r;
    endfunction

    // Accumulate one element; on the closing one, queue the expected score
    task automatic score_element(input t_elem e);
        logic [63:0] add;
        logic [63:0] acc;
        logic [63:0] dv;
        t_score      s;
        if (mdl_cnt < MAX_RES) begin
            add = mdl_mode ? 64'(e.qty) * 64'(e.wgt) : 64'(e.qty) << 8;
            acc = 64'(mdl_sum) + add;
            if (acc > 64'(SUM_MAX))
                acc = 64'(SUM_MAX);
            mdl_sum = acc[SUM_W-1:0];
            mdl_cnt++;
        end
        if (e.last) begin
            dv = mdl_mode ? floor_root(64'(mdl_sum) << 8) : 64'(mdl_sum);
            s.idx = mdl_bid;
            if (dv == 0) begin
                s.score = SCORE_SAT;
                s.zero  = 1'b1;
                n_zero++;
            end else begin
                s.score = SCORE_W'((64'(e.val) << 8) / dv);
                s.zero  = 1'b0;
            end
            pending_scores.push_back(s);
            mdl_bid = mdl_bid + 1'b1;
            mdl_sum = '0;
            mdl_cnt = 0;
        end
    endtask

    function automatic int draw_wait(input bit steady);
        return steady ? 0 : $urandom_range(0, 15);
    endfunction

    // Input driver
    t_elem cur_elem;
    int    in_gap    = 0;
    bit    in_steady = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap     <= 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                score_element(cur_elem);
                n_elems++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (in_gap != 0) begin
                    in_gap     <= in_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (bid_elems.size() != 0) begin
                    cur_elem       = bid_elems.pop_front();
                    i_quantity    <= cur_elem.qty;
                    i_weight      <= cur_elem.wgt;
                    i_bid_value   <= cur_elem.val;
                    i_last_of_bid <= cur_elem.last;
                    i_in_valid    <= 1'b1;
                    if ($urandom_range(0, 31) == 0)
                        in_steady = ~in_steady;
                    in_gap        <= draw_wait(in_steady);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor and checker
    int     out_gap    = 0;
    bit     out_steady = 1'b0;
    int     g;
    t_score want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_gap     <= 0;
        end else if (o_out_valid && i_out_ready) begin
            n_scores++;
            if (pending_scores.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected score idx=%0d score=%h zero=%b",
                             o_bid_index, o_score, o_zero_divisor);
            end else begin
                want = pending_scores.pop_front();
                if (o_bid_index !== want.idx || o_score !== want.score ||
                    o_zero_divisor !== want.zero) begin
                    errors++;
                    if (errors <= 10)
                        $display({"ERROR: bid %0d exp idx=%0d score=%h zero=%b ",
                                  "got idx=%0d score=%h zero=%b"},
                                 want.idx, want.idx, want.score, want.zero,
                                 o_bid_index, o_score, o_zero_divisor);
                end
            end
            if ($urandom_range(0, 31) == 0)
                out_steady = ~out_steady;
            g = draw_wait(out_steady);
            out_gap     <= g;
            i_out_ready <= (g == 0);
        end else if (out_gap != 0) begin
            out_gap     <= out_gap - 1;
            i_out_ready <= (out_gap == 1);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic push_elem(input logic [QTY_W-1:0] q, input logic [WGT_W-1:0] w,
                             input logic [VAL_W-1:0] v, input logic l);
        t_elem e;
        e.qty  = q;
        e.wgt  = w;
        e.val  = v;
        e.last = l;
        bid_elems.push_back(e);
    endtask

    // Block until everything sent has been scored and the core has settled;
    // sampled at the falling edge so driver updates are already visible
    task automatic wait_idle();
        @(negedge i_clk);
        while (bid_elems.size() != 0 || i_in_valid || pending_scores.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        mdl_mode    = m;
    endtask

    function automatic logic [15:0] pick16();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(0, 3));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    // One random bid row; an open row leaves the bid for the next phase to close
    task automatic gen_bid(input bit close, inout int n_items);
        int len;
        if ($urandom_range(0, 15) == 0) begin
            len = $urandom_range(MAX_RES - 4, MAX_RES + 6);
            if (len > MAX_RES)
                n_long++;
        end else begin
            len = $urandom_range(1, 8);
        end
        for (int i = 0; i < len; i++)
            push_elem(pick16(), pick16(), pick32(), close && (i == len - 1));
        n_items += len;
    endtask

    int n_items;

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: density mode
        write_mode(1'b1);
        push_elem(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        push_elem(16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);  // zero quantity
        push_elem(16'h0001, 16'h0001, 32'hFFFF_FFFF, 1'b1);  // smallest nonzero root
        push_elem(16'hFFFF, 16'h0000, 32'h1234_5678, 1'b1);  // zero weight
        push_elem(16'h0003, 16'h0100, 32'h0000_0000, 1'b1);  // zero value
        push_elem(16'h000A, 16'h0080, 32'h5555_5555, 1'b0);
        push_elem(16'h0014, 16'h0200, 32'hAAAA_AAAA, 1'b0);
        push_elem(16'h0000, 16'h0000, 32'hABCD_0000, 1'b1);
        // bid left open across a switch to average mode
        push_elem(16'h0007, 16'h0300, 32'hFFFF_FFFF, 1'b0);
        push_elem(16'h0009, 16'h0040, 32'h0000_0000, 1'b0);
        wait_idle();
        write_mode(1'b0);
        push_elem(16'h0005, 16'hFFFF, 32'h0001_0000, 1'b1);

        // Directed: average mode
        push_elem(16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);  // zero sum
        push_elem(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 1'b1);
        push_elem(16'h0001, 16'h0000, 32'hFFFF_FFFF, 1'b1);  // largest score
        push_elem(16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
        push_elem(16'h0000, 16'h0000, 32'h0000_0005, 1'b1);
        // and back to density inside a bid
        push_elem(16'h0064, 16'h1234, 32'h0000_0001, 1'b0);
        wait_idle();
        write_mode(1'b1);
        push_elem(16'h0064, 16'h0100, 32'h7FFF_FFFF, 1'b1);
        wait_idle();

        // Random phases, alternating mode
        for (int ph = 0; ph < 4; ph++) begin
            write_mode(ph[0]);
            n_items = 0;
            while (n_items < 200)
                gen_bid(1'b1, n_items);
            if (ph < 3 && $urandom_range(0, 1) == 1)
                gen_bid(1'b0, n_items);
            wait_idle();
        end

        $display("Scored %0d bids from %0d elements over both modes", n_scores, n_elems);
        $display("%0d zero-divisor bids, %0d rows past the resource limit", n_zero, n_long);
        if (errors == 0 && pending_scores.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches, %0d scores missing", errors, pending_scores.size());
            $display("FAIL");
        end
        $finish;
    end

endmodule
